>>> rtl/rpb_pkg.sv
// Shared types, constants and lane operation codes for the RGBA pixel blend unit.
package rpb_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned LANES   = 4;
  localparam int unsigned ALPHA_L = 3;
  localparam logic [CH_W-1:0] FULL = 8'hFF;

  typedef enum logic [2:0] {
    OP_GAMMA    = 3'd0,
    OP_SCALE    = 3'd1,
    OP_OVERLAY  = 3'd2,
    OP_ROVERLAY = 3'd3,
    OP_MERGE    = 3'd4,
    OP_MULTOP   = 3'd5,
    OP_MULSC    = 3'd6,
    OP_ADD      = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    LOP_GAMMA,
    LOP_SCALE,
    LOP_OVERLAY,
    LOP_ROVERLAY,
    LOP_MERGE,
    LOP_MULTOP,
    LOP_MULSC,
    LOP_ADD,
    LOP_PASS
  } lane_op_t;

  typedef struct packed {
    lane_op_t        op;
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] t;
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] ta;
  } lane_in_t;

endpackage

>>> rtl/rpb_lane.sv
// One colour channel lane: operand select, two products, then the multiply-top second product.
module rpb_lane (
  input  logic                     clk,
  input  rpb_pkg::lane_in_t        lane_i,
  output logic [rpb_pkg::CH_W-1:0] res_o
);

  localparam int unsigned W  = rpb_pkg::CH_W;
  localparam int unsigned PW = 2 * rpb_pkg::CH_W;

  function automatic logic [W-1:0] rnd_scale(input logic [PW-1:0] p);
    logic [W:0] s;
    s = {1'b0, p[PW-1:W]} + {{W{1'b0}}, p[W-1]};
    return s[W-1:0];
  endfunction

  logic [W-1:0]  na, nta, x0, x1;
  logic [PW-1:0] m0, m1;
  logic [PW:0]   sum_p;
  logic [W:0]    sum_c;
  logic [W:0]    sum_r;
  logic [W-1:0]  res_nxt, w_nxt;

  logic [W-1:0]      res_r, w_r, c_r;
  rpb_pkg::lane_op_t op_r;
  logic [PW-1:0]     m2;

  assign na  = rpb_pkg::FULL - lane_i.a;
  assign nta = rpb_pkg::FULL - lane_i.ta;

  always_comb begin
    x0 = lane_i.a;
    x1 = lane_i.a;
    case (lane_i.op)
      rpb_pkg::LOP_GAMMA: x0 = lane_i.c;
      rpb_pkg::LOP_OVERLAY, rpb_pkg::LOP_ROVERLAY: x0 = na;
      rpb_pkg::LOP_MERGE: begin
        x0 = nta;
        x1 = lane_i.ta;
      end
      rpb_pkg::LOP_MULTOP: x1 = lane_i.ta;
      default: begin
        x0 = lane_i.a;
        x1 = lane_i.a;
      end
    endcase
  end

  assign m0    = {{W{1'b0}}, lane_i.c} * {{W{1'b0}}, x0};
  assign m1    = {{W{1'b0}}, lane_i.t} * {{W{1'b0}}, x1};
  assign sum_p = {1'b0, m0} + {1'b0, m1};
  assign sum_c = {1'b0, lane_i.c} + {1'b0, lane_i.t};
  assign sum_r = {1'b0, rnd_scale(m0)} + {1'b0, rnd_scale(m1)};
  assign w_nxt = nta + m1[PW-1:W];

  always_comb begin
    res_nxt = lane_i.c;
    unique case (lane_i.op)
      rpb_pkg::LOP_GAMMA,
      rpb_pkg::LOP_MULSC:    res_nxt = m0[PW-1:W];
      rpb_pkg::LOP_SCALE:    res_nxt = rnd_scale(m0);
      rpb_pkg::LOP_OVERLAY,
      rpb_pkg::LOP_MERGE:    res_nxt = sum_p[PW-1:W];
      rpb_pkg::LOP_ROVERLAY: res_nxt = sum_r[W-1:0];
      rpb_pkg::LOP_ADD:      res_nxt = sum_c[W] ? rpb_pkg::FULL : sum_c[W-1:0];
      rpb_pkg::LOP_MULTOP,
      rpb_pkg::LOP_PASS:     res_nxt = lane_i.c;
      default:               res_nxt = lane_i.c;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    w_r   <= w_nxt;
    c_r   <= lane_i.c;
    op_r  <= lane_i.op;
  end

  assign m2    = {{W{1'b0}}, c_r} * {{W{1'b0}}, w_r};
  assign res_o = (op_r == rpb_pkg::LOP_MULTOP) ? m2[PW-1:W] : res_r;

endmodule

>>> rtl/rpb_merge.sv
// Output stage: gathers the four lane results into one RGBA beat with its strobe.
module rpb_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      vld_i,
  input  logic [rpb_pkg::LANES-1:0][rpb_pkg::CH_W-1:0] res_i,
  output logic                                      out_valid,
  output logic [rpb_pkg::CH_W-1:0]                  out_red,
  output logic [rpb_pkg::CH_W-1:0]                  out_green,
  output logic [rpb_pkg::CH_W-1:0]                  out_blue,
  output logic [rpb_pkg::CH_W-1:0]                  out_alpha
);

  logic                                          vld_r;
  logic [rpb_pkg::LANES-1:0][rpb_pkg::CH_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i) begin
      pix_r <= res_i;
    end
  end

  assign out_valid = vld_r;
  assign out_red   = pix_r[0];
  assign out_green = pix_r[1];
  assign out_blue  = pix_r[2];
  assign out_alpha = pix_r[rpb_pkg::ALPHA_L];

endmodule

>>> rtl/rgba_pixel_blend_unit.sv
// Top level of the RGBA pixel blend unit: weight stage, four channel lanes, output merge.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+------------------------------
//   input    | in_operation, in_base_*,      | start && !busy
//            | in_top_*, in_amount           |
//   result   | out_red/green/blue/alpha      | out_valid, one cycle, no stall
//
// One beat per cycle. The pipeline registers follow the multiplier chain
// of multiply-top: top alpha times amount, then the weighted top channel, then
// the base channel times the resulting factor, each behind a register.
// Synchronous active-low reset clears the valid pipeline; busy stays low.
// The receiver cannot stall, so nothing ever holds the pipeline.
module rgba_pixel_blend_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_operation,
  input  logic [rpb_pkg::CH_W-1:0] in_base_red,
  input  logic [rpb_pkg::CH_W-1:0] in_base_green,
  input  logic [rpb_pkg::CH_W-1:0] in_base_blue,
  input  logic [rpb_pkg::CH_W-1:0] in_base_alpha,
  input  logic [rpb_pkg::CH_W-1:0] in_top_red,
  input  logic [rpb_pkg::CH_W-1:0] in_top_green,
  input  logic [rpb_pkg::CH_W-1:0] in_top_blue,
  input  logic [rpb_pkg::CH_W-1:0] in_top_alpha,
  input  logic [rpb_pkg::CH_W-1:0] in_amount,
  output logic                     out_valid,
  output logic [rpb_pkg::CH_W-1:0] out_red,
  output logic [rpb_pkg::CH_W-1:0] out_green,
  output logic [rpb_pkg::CH_W-1:0] out_blue,
  output logic [rpb_pkg::CH_W-1:0] out_alpha
);

  localparam int unsigned W = rpb_pkg::CH_W;

  logic                 acc;
  logic [2*W-1:0]       ta_p;
  logic [W-1:0]         ta;
  rpb_pkg::op_t         op;
  rpb_pkg::lane_op_t    rgb_op, a_op;
  logic [W-1:0]         a_t;
  logic [rpb_pkg::LANES-1:0][W-1:0] base_c, top_c;

  rpb_pkg::lane_in_t                  lane_nxt [rpb_pkg::LANES];
  rpb_pkg::lane_in_t                  lane_r   [rpb_pkg::LANES];
  logic [rpb_pkg::LANES-1:0][W-1:0]   lane_res;
  logic                               s1_vld_r, s2_vld_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign op   = rpb_pkg::op_t'(in_operation);
  assign ta_p = {{W{1'b0}}, in_top_alpha} * {{W{1'b0}}, in_amount};
  assign ta   = ta_p[2*W-1:W];

  assign base_c = {in_base_alpha, in_base_blue, in_base_green, in_base_red};
  assign top_c  = {in_top_alpha, in_top_blue, in_top_green, in_top_red};

  always_comb begin
    rgb_op = rpb_pkg::LOP_PASS;
    a_op   = rpb_pkg::LOP_PASS;
    a_t    = in_top_alpha;
    unique case (op)
      rpb_pkg::OP_GAMMA:    rgb_op = rpb_pkg::LOP_GAMMA;
      rpb_pkg::OP_SCALE:    rgb_op = rpb_pkg::LOP_SCALE;
      rpb_pkg::OP_OVERLAY:  rgb_op = rpb_pkg::LOP_OVERLAY;
      rpb_pkg::OP_ROVERLAY: rgb_op = rpb_pkg::LOP_ROVERLAY;
      rpb_pkg::OP_MERGE: begin
        rgb_op = rpb_pkg::LOP_MERGE;
        a_op   = rpb_pkg::LOP_MERGE;
      end
      rpb_pkg::OP_MULTOP:   rgb_op = rpb_pkg::LOP_MULTOP;
      rpb_pkg::OP_MULSC:    rgb_op = rpb_pkg::LOP_MULSC;
      rpb_pkg::OP_ADD: begin
        // alpha accumulates the weight rather than the top alpha
        rgb_op = rpb_pkg::LOP_ADD;
        a_op   = rpb_pkg::LOP_ADD;
        a_t    = ta;
      end
      default: begin
        rgb_op = rpb_pkg::LOP_PASS;
        a_op   = rpb_pkg::LOP_PASS;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < rpb_pkg::LANES; i++) begin
      lane_nxt[i].op = rgb_op;
      lane_nxt[i].c  = base_c[i];
      lane_nxt[i].t  = top_c[i];
      lane_nxt[i].a  = in_amount;
      lane_nxt[i].ta = ta;
    end
    lane_nxt[rpb_pkg::ALPHA_L].op = a_op;
    lane_nxt[rpb_pkg::ALPHA_L].t  = a_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      lane_r <= lane_nxt;
    end
  end

  for (genvar g = 0; g < rpb_pkg::LANES; g++) begin : g_lane
    rpb_lane u_lane (
      .clk    (clk),
      .lane_i (lane_r[g]),
      .res_o  (lane_res[g])
    );
  end

  rpb_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (s2_vld_r),
    .res_i     (lane_res),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  a_out_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 3))
    else $error("result beat without an accepted input beat");

  a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_operation, 3) != rpb_pkg::OP_MERGE
      && $past(in_operation, 3) != rpb_pkg::OP_ADD
    |-> out_alpha == $past(in_base_alpha, 3))
    else $error("alpha changed by an operation that keeps it");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_operation, 3) == rpb_pkg::OP_ADD
    |-> out_red >= $past(in_base_red, 3) && out_alpha >= $past(in_base_alpha, 3))
    else $error("saturating add decreased a channel");

  a_gamma_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_operation, 3) == rpb_pkg::OP_GAMMA
    |-> out_green <= $past(in_base_green, 3))
    else $error("gamma raised a channel");

endmodule
